### src/sopt_pkg.sv
package sopt_pkg;

    // table geometry
    localparam int MAX_TIMERS  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int BUF_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    // time base and exact divide by ten (reciprocal, shift 35)
    localparam logic [31:0] MS_PER_TICK = 32'd10;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // stream widths
    localparam int IN_DATA_W  = 232;
    localparam int OUT_DATA_W = 240;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RES_START = 2'd0,
        RES_STOP  = 2'd1,
        RES_QUERY = 2'd2,
        RES_FIRE  = 2'd3
    } res_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    localparam logic [1:0] KIND_PERIODIC = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_START_CHK,
        S_START_REPLY,
        S_ID_SCAN,
        S_ID_REPLY,
        S_TICK_SCAN,
        S_TICK_DECIDE,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_START,
        OP_START_REPLY,
        OP_ID_STEP,
        OP_ID_REPLY,
        OP_TICK_STEP,
        OP_FIRE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    tid_zero;
        logic    scan_last;
        logic    best_valid;
        logic    fire_full;
        logic    nfire_zero;
        logic    emit_last;
        logic    out_free;
    } stat_t;

endpackage

### src/sopt_ctrl.sv
module sopt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sopt_pkg::stat_t stat,
    output sopt_pkg::cmd_t  cmd
);
    import sopt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // advance
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.act)
                    ACT_START: state_next = S_START_CHK;
                    ACT_STOP,
                    ACT_QUERY: state_next = stat.tid_zero ? S_ID_REPLY : S_ID_SCAN;
                    default:   state_next = S_TICK_SCAN;
                endcase
            end
            S_START_CHK:   state_next = S_START_REPLY;
            S_START_REPLY:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ID_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_ID_REPLY;
                end
            end
            S_ID_REPLY:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_TICK_DECIDE;
                end
            end
            S_TICK_DECIDE:
            begin
                if (!stat.best_valid)
                begin
                    state_next = stat.nfire_zero ? S_IDLE : S_EMIT;
                end
                else
                begin
                    state_next = stat.fire_full ? S_EMIT : S_TICK_SCAN;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // drive datapath commands
    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_ACCEPT;
                end
            end
            S_START_CHK:   cmd.op = OP_START;
            S_START_REPLY: cmd.op = stat.out_free ? OP_START_REPLY : OP_NONE;
            S_ID_SCAN:     cmd.op = OP_ID_STEP;
            S_ID_REPLY:    cmd.op = stat.out_free ? OP_ID_REPLY : OP_NONE;
            S_TICK_SCAN:   cmd.op = OP_TICK_STEP;
            S_TICK_DECIDE: cmd.op = stat.best_valid ? OP_FIRE : OP_NONE;
            S_EMIT:        cmd.op = stat.out_free ? OP_EMIT : OP_NONE;
            default:       cmd.op = OP_NONE;
        endcase
    end

endmodule

### src/sopt_dpath.sv
module sopt_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sopt_pkg::cmd_t                   cmd,
    output sopt_pkg::stat_t                  stat,
    input  logic [sopt_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sopt_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [31:0]                      cfg_data
);
    import sopt_pkg::*;

    // captured input word
    logic [1:0]  act_reg;
    logic [31:0] dur_reg;
    logic [1:0]  kind_reg;
    logic [63:0] tgt_reg;
    logic [31:0] command_reg;
    logic [31:0] hnd_reg;
    logic [31:0] src_reg;
    logic [31:0] tid_reg;

    // timer table
    logic [MAX_TIMERS-1:0] valid_reg;
    logic [31:0] slot_id_reg     [MAX_TIMERS];
    logic [31:0] slot_exp_reg    [MAX_TIMERS];
    logic [31:0] slot_per_reg    [MAX_TIMERS];
    logic        slot_pdc_reg    [MAX_TIMERS];
    logic [63:0] slot_tgt_reg    [MAX_TIMERS];
    logic [31:0] slot_cmd_reg    [MAX_TIMERS];
    logic [31:0] slot_hnd_reg    [MAX_TIMERS];
    logic [31:0] slot_src_reg    [MAX_TIMERS];
    logic [31:0] slot_ord_reg    [MAX_TIMERS];

    // global counters and limits
    logic [31:0]      now_reg;
    logic [31:0]      next_id_reg;
    logic [31:0]      order_reg;
    logic [CNT_W-1:0] armed_reg;
    logic [CNT_W-1:0] armed_next;
    logic [31:0]      min_reg;
    logic [31:0]      max_reg;

    // scan and start state
    logic [IDX_W-1:0] scan_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [31:0]      found_hnd_reg;
    logic [31:0]      found_src_reg;
    logic [31:0]      found_exp_reg;
    logic             best_valid_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_d_reg;
    logic [31:0]      best_rel_reg;
    logic [31:0]      best_exp_reg;
    logic [31:0]      best_per_reg;
    logic             best_pdc_reg;
    logic             bad_reg;
    logic             full_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [63:0]      prod_reg;

    // fire list
    logic [IDX_W-1:0] buf_reg [MAX_RESULTS];
    logic [RES_W-1:0] nfire_reg;
    logic [RES_W-1:0] emit_k_reg;

    // result word
    logic        out_valid_reg;
    logic [1:0]  o_kind_reg;
    logic [1:0]  o_status_reg;
    logic [31:0] o_id_reg;
    logic        o_run_reg;
    logic [31:0] o_rem_reg;
    logic [63:0] o_addr_reg;
    logic [31:0] o_cmd_reg;
    logic [31:0] o_hnd_reg;
    logic [31:0] o_src_reg;
    logic        o_pdc_reg;
    logic        o_last_reg;
    logic [5:0]  o_act_reg;

    // combinational helpers
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      rd_id;
    logic [31:0]      rd_exp;
    logic [31:0]      rd_ord;
    logic             rd_valid;
    logic [IDX_W-1:0] free_idx;
    logic             has_free;
    logic             scan_last;
    logic             out_free;
    logic             start_ok;
    logic [31:0]      period;
    logic [31:0]      id_plus;
    logic [31:0]      tick_d;
    logic [31:0]      tick_rel;
    logic             tick_due;
    logic             tick_better;
    logic [31:0]      q_d;
    logic [34:0]      q_ms;
    logic [31:0]      q_rem;
    logic             emit_last;

    assign scan_last = (scan_idx_reg == IDX_W'(MAX_TIMERS - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_last = (emit_k_reg == RES_W'(nfire_reg - 1'b1));

    // one table read port, steered by the phase
    assign rd_idx   = (cmd.op == OP_EMIT) ? buf_reg[emit_k_reg[BUF_W-1:0]] : scan_idx_reg;
    assign rd_id    = slot_id_reg[rd_idx];
    assign rd_exp   = slot_exp_reg[rd_idx];
    assign rd_ord   = slot_ord_reg[rd_idx];
    assign rd_valid = valid_reg[rd_idx];

    // lowest free entry
    always_comb
    begin
        free_idx = '0;
        has_free = 1'b0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                has_free = 1'b1;
            end
        end
    end

    // start arithmetic
    assign start_ok = !bad_reg && !full_reg;
    assign period   = (dur_reg <= MS_PER_TICK) ? 32'd1 : 32'(prod_reg >> RECIP_SHIFT);
    assign id_plus  = next_id_reg + 32'd1;

    // earliest due entry: signed distance, then arming order
    assign tick_d      = rd_exp - now_reg;
    assign tick_rel    = rd_ord - order_reg;
    assign tick_due    = rd_valid && ((tick_d == 32'd0) || tick_d[31]);
    assign tick_better = !best_valid_reg || ($signed(tick_d) < $signed(best_d_reg)) ||
                         ((tick_d == best_d_reg) && (tick_rel < best_rel_reg));

    // remaining time of a queried timer, saturated
    assign q_d  = found_exp_reg - now_reg;
    assign q_ms = {q_d, 3'b000} + {2'b00, q_d, 1'b0};
    always_comb
    begin
        if (q_d[31] || (q_d == 32'd0))
        begin
            q_rem = 32'd0;
        end
        else if (q_ms[34:32] != 3'd0)
        begin
            q_rem = 32'hFFFF_FFFF;
        end
        else
        begin
            q_rem = q_ms[31:0];
        end
    end

    // armed count after this cycle
    always_comb
    begin
        armed_next = armed_reg;
        case (cmd.op)
            OP_START_REPLY:
            begin
                if (start_ok)
                begin
                    armed_next = armed_reg + 1'b1;
                end
            end
            OP_ID_REPLY:
            begin
                if ((act_reg == ACT_STOP) && found_reg)
                begin
                    armed_next = armed_reg - 1'b1;
                end
            end
            OP_FIRE:
            begin
                if (!best_pdc_reg)
                begin
                    armed_next = armed_reg - 1'b1;
                end
            end
            default: armed_next = armed_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            now_reg        <= '0;
            next_id_reg    <= 32'd1;
            order_reg      <= '0;
            armed_reg      <= '0;
            min_reg        <= 32'd10;
            max_reg        <= 32'd86400000;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            nfire_reg      <= '0;
            emit_k_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                begin
                    min_reg <= cfg_data;
                end
                else
                begin
                    max_reg <= cfg_data;
                end
            end
            // load a new result word, or drop the one just taken
            if (cmd.op inside {OP_START_REPLY, OP_ID_REPLY, OP_EMIT})
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_ACCEPT:
                begin
                    if (s_tuser == ACT_TICK)
                    begin
                        now_reg <= now_reg + 32'd1;
                    end
                    scan_idx_reg   <= '0;
                    found_reg      <= 1'b0;
                    best_valid_reg <= 1'b0;
                    nfire_reg      <= '0;
                    emit_k_reg     <= '0;
                end
                OP_START_REPLY:
                begin
                    if (start_ok)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        next_id_reg <= (id_plus == 32'd0) ? 32'd1 : id_plus;
                        order_reg   <= order_reg + 32'd1;
                    end
                end
                OP_ID_STEP:
                begin
                    scan_idx_reg <= scan_last ? '0 : scan_idx_reg + 1'b1;
                    if (!found_reg && rd_valid && (rd_id == tid_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                OP_ID_REPLY:
                begin
                    if ((act_reg == ACT_STOP) && found_reg)
                    begin
                        valid_reg[found_idx_reg] <= 1'b0;
                    end
                end
                OP_TICK_STEP:
                begin
                    scan_idx_reg <= scan_last ? '0 : scan_idx_reg + 1'b1;
                    if (tick_due && tick_better)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                end
                OP_FIRE:
                begin
                    nfire_reg      <= nfire_reg + 1'b1;
                    best_valid_reg <= 1'b0;
                    scan_idx_reg   <= '0;
                    if (best_pdc_reg)
                    begin
                        order_reg <= order_reg + 32'd1;
                    end
                    else
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
                OP_EMIT:
                begin
                    emit_k_reg <= emit_k_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                act_reg     <= s_tuser;
                dur_reg     <= s_tdata[31:0];
                kind_reg    <= s_tdata[33:32];
                tgt_reg     <= s_tdata[97:34];
                command_reg <= s_tdata[129:98];
                hnd_reg     <= s_tdata[161:130];
                src_reg     <= s_tdata[193:162];
                tid_reg     <= s_tdata[225:194];
            end
            OP_START:
            begin
                bad_reg      <= (dur_reg < min_reg) || (dur_reg > max_reg) ||
                                (kind_reg > KIND_PERIODIC);
                full_reg     <= (armed_reg >= CNT_W'(MAX_TIMERS)) || !has_free;
                free_idx_reg <= free_idx;
                prod_reg     <= dur_reg * RECIP_TEN;
            end
            OP_START_REPLY:
            begin
                if (start_ok)
                begin
                    slot_id_reg[free_idx_reg]  <= next_id_reg;
                    slot_per_reg[free_idx_reg] <= period;
                    slot_exp_reg[free_idx_reg] <= now_reg + period;
                    slot_pdc_reg[free_idx_reg] <= (kind_reg == KIND_PERIODIC);
                    slot_tgt_reg[free_idx_reg] <= tgt_reg;
                    slot_cmd_reg[free_idx_reg] <= command_reg;
                    slot_hnd_reg[free_idx_reg] <= hnd_reg;
                    slot_src_reg[free_idx_reg] <= src_reg;
                    slot_ord_reg[free_idx_reg] <= order_reg;
                end
                o_kind_reg   <= RES_START;
                o_status_reg <= start_ok ? ST_OK : (bad_reg ? ST_INVALID : ST_FULL);
                o_id_reg     <= start_ok ? next_id_reg : 32'd0;
                o_run_reg    <= 1'b0;
                o_rem_reg    <= '0;
                o_addr_reg   <= '0;
                o_cmd_reg    <= '0;
                o_hnd_reg    <= '0;
                o_src_reg    <= '0;
                o_pdc_reg    <= 1'b0;
                o_last_reg   <= 1'b1;
                o_act_reg    <= 6'(armed_next);
            end
            OP_ID_STEP:
            begin
                if (!found_reg && rd_valid && (rd_id == tid_reg))
                begin
                    found_idx_reg <= scan_idx_reg;
                    found_hnd_reg <= slot_hnd_reg[rd_idx];
                    found_src_reg <= slot_src_reg[rd_idx];
                    found_exp_reg <= rd_exp;
                end
            end
            OP_ID_REPLY:
            begin
                o_kind_reg <= act_reg;
                o_run_reg  <= 1'b0;
                o_rem_reg  <= '0;
                o_addr_reg <= '0;
                o_cmd_reg  <= '0;
                o_hnd_reg  <= '0;
                o_src_reg  <= '0;
                o_pdc_reg  <= 1'b0;
                o_last_reg <= 1'b1;
                o_act_reg  <= 6'(armed_next);
                if (tid_reg == 32'd0)
                begin
                    o_status_reg <= ST_INVALID;
                    o_id_reg     <= 32'd0;
                end
                else if (!found_reg)
                begin
                    o_status_reg <= ST_NOTFOUND;
                    o_id_reg     <= tid_reg;
                end
                else
                begin
                    o_status_reg <= ST_OK;
                    o_id_reg     <= tid_reg;
                    if (act_reg == ACT_STOP)
                    begin
                        o_hnd_reg <= found_hnd_reg;
                        o_src_reg <= found_src_reg;
                    end
                    else
                    begin
                        o_run_reg <= 1'b1;
                        o_rem_reg <= q_rem;
                    end
                end
            end
            OP_TICK_STEP:
            begin
                if (tick_due && tick_better)
                begin
                    best_idx_reg <= scan_idx_reg;
                    best_d_reg   <= tick_d;
                    best_rel_reg <= tick_rel;
                    best_exp_reg <= rd_exp;
                    best_per_reg <= slot_per_reg[rd_idx];
                    best_pdc_reg <= slot_pdc_reg[rd_idx];
                end
            end
            OP_FIRE:
            begin
                buf_reg[nfire_reg[BUF_W-1:0]] <= best_idx_reg;
                if (best_pdc_reg)
                begin
                    slot_exp_reg[best_idx_reg] <= best_exp_reg + best_per_reg;
                    slot_ord_reg[best_idx_reg] <= order_reg;
                end
            end
            OP_EMIT:
            begin
                o_kind_reg   <= RES_FIRE;
                o_status_reg <= ST_OK;
                o_id_reg     <= rd_id;
                o_run_reg    <= 1'b0;
                o_rem_reg    <= '0;
                o_addr_reg   <= slot_tgt_reg[rd_idx];
                o_cmd_reg    <= slot_cmd_reg[rd_idx];
                o_hnd_reg    <= slot_hnd_reg[rd_idx];
                o_src_reg    <= slot_src_reg[rd_idx];
                o_pdc_reg    <= slot_pdc_reg[rd_idx];
                o_last_reg   <= emit_last;
                o_act_reg    <= 6'(armed_reg);
            end
            default:
            begin
            end
        endcase
    end

    // status to controller
    assign stat.act        = action_t'(act_reg);
    assign stat.tid_zero   = (tid_reg == 32'd0);
    assign stat.scan_last  = scan_last;
    assign stat.best_valid = best_valid_reg;
    assign stat.fire_full  = (nfire_reg == RES_W'(MAX_RESULTS - 1));
    assign stat.nfire_zero = (nfire_reg == '0);
    assign stat.emit_last  = emit_last;
    assign stat.out_free   = out_free;

    // result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {6'd0, o_act_reg, o_pdc_reg, o_src_reg, o_hnd_reg, o_cmd_reg,
                       o_addr_reg, o_rem_reg, o_run_reg, o_id_reg, o_status_reg};

endmodule

### src/sorted_oneshot_periodic_timer_table.sv
// Timer table with one-shot and periodic timers, time counted in 10 ms ticks.
// Input stream s_*: one word per request; s_tuser carries the action (start,
// stop, query, tick) and s_tdata the request fields. Output stream m_*: one
// reply word per start, stop or query; a tick gives one word per fired
// timer, earliest expiry first, and none when nothing is due. m_tlast marks
// the final word caused by a request, m_tuser carries the result kind.
// cfg_we/cfg_index/cfg_data write the minimum (index 0) and maximum
// (index 1) accepted duration in ms; the user must write them only while
// the block is idle, which the block itself does not enforce.
// One request is handled at a time. A start is checked and then answered;
// a stop or query walks all table entries through one read port, unless
// the id is zero. A tick walks the table once, again after each fired
// timer, and then emits one word per fired timer; a tick that fires the
// most words at once skips the closing walk.
// Reset clears the table and the clock and sets the id counter to 1, and
// the block leaves reset idle and ready. A stalled m_tready holds the
// result word and holds the controller until the word is taken.
module sorted_oneshot_periodic_timer_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // duration, timer_kind, destination, command, payload_handle,
    // payload_source, id, zero fill
    input  logic [sopt_pkg::IN_DATA_W-1:0]   s_tdata,
    // action
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, result_id, timer_running, time_left, fire_address,
    // fire_command, out_handle, out_source, fire_periodic, active_count, zero fill
    output logic [sopt_pkg::OUT_DATA_W-1:0]  m_tdata,
    // result_kind
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [31:0]                      cfg_data
);
    import sopt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequence the request
    sopt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, counters and result word
    sopt_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### src/sopt_checker.sv
module sopt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sopt_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                       m_tuser,
    input logic                             m_tlast
);
    import sopt_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // a request keeps the block busy for the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // fired timers always report ok
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == RES_FIRE) |-> (m_tdata[1:0] == ST_OK))
        else $error("fire word with bad status");

    // a refused start carries no id
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == RES_START) && (m_tdata[1:0] != ST_OK)
        |-> (m_tdata[33:2] == 32'd0) && m_tlast)
        else $error("refused start with id");

endmodule

bind sorted_oneshot_periodic_timer_table sopt_checker u_sopt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
